@@ rtl/core/sfir_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, widths and control structs of the saturating FIR filter.
package sfir_pkg;

  localparam int MAX_COEFS   = 128;
  localparam int DELAY_DEPTH = 256;

  // tap-group clamps, limited by table and delay depth
  localparam int PQ_A       = (32 < MAX_COEFS / 4) ? 32 : MAX_COEFS / 4;
  localparam int PLAIN_QMAX = (PQ_A < DELAY_DEPTH / 4) ? PQ_A : DELAY_DEPTH / 4;
  localparam int SQ_A       = (31 < (MAX_COEFS - 1) / 4) ? 31 : (MAX_COEFS - 1) / 4;
  localparam int SYM_QMAX   = (SQ_A < (DELAY_DEPTH - 1) / 8) ? SQ_A : (DELAY_DEPTH - 1) / 8;

  // samples held in the ring: oldest sample any mode can reach, plus one
  localparam int RING_LEN = (4 * PLAIN_QMAX > 8 * SYM_QMAX + 1) ?
                            4 * PLAIN_QMAX : 8 * SYM_QMAX + 1;

  localparam int CNT_W   = $clog2(RING_LEN + 1);
  localparam int COEF_AW = $clog2(MAX_COEFS);
  localparam int ACC_W   = 33 + $clog2(RING_LEN);

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 16;
  localparam int CIDX_W     = 7;
  localparam int QC_W       = 6;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;
  localparam int FRAC_BITS  = 14;
  localparam int ROUND_BIAS = 'h2000;

  localparam logic [CFG_IDX_W-1:0] REG_SYMMETRIC  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_QUAD_COUNT = 1'b1;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_COEF   = 1'b1;

  localparam logic [SAMPLE_W-1:0] SAT_MAX = 16'h7fff;
  localparam logic [SAMPLE_W-1:0] SAT_MIN = 16'h8000;

  typedef struct packed {
    logic shift;
    logic load;
  } chain_ctl_t;

  typedef struct packed {
    logic clear;
    logic act;
    logic cvld;
  } mac_ctl_t;

endpackage

@@ rtl/core/saturating_fir_audio_filter.sv @@
`timescale 1ns / 1ps
// Saturating FIR audio filter top level: sequencer, coefficient table and ring.
// Samples: the next sample is not accepted until the current one has been walked once
// around the sample ring past the single MAC, drained and loaded into the output register;
// coefficient writes are accepted only while no sample is in flight.
// Reset (rst_n low, synchronous): delay ring zeroed, coefficient table reads as zero,
// symmetric = 0, quad_count = 1, no result pending.
module saturating_fir_audio_filter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [15:0] sample, [22:16] coef_index, [38:23] coef_value, [39] zero
  input  logic [sfir_pkg::IN_DATA_W-1:0]    in_tdata,
  // [0] mode
  input  logic [0:0]                        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [15:0] filtered
  output logic [sfir_pkg::OUT_DATA_W-1:0]   out_tdata,
  // [0] clipped
  output logic [0:0]                        out_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sfir_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sfir_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_WALK = 3'd1;
  localparam logic [2:0] ST_DRN1 = 3'd2;
  localparam logic [2:0] ST_DRN2 = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  localparam int CW = sfir_pkg::CNT_W;
  localparam int QW = sfir_pkg::QC_W;
  localparam logic [CW-1:0] M_LAST = CW'(sfir_pkg::RING_LEN - 1);
  localparam logic [QW-1:0] PQ_MAX = QW'(sfir_pkg::PLAIN_QMAX);
  localparam logic [QW-1:0] SQ_MAX = QW'(sfir_pkg::SYM_QMAX);

  logic [2:0]                          state_r, state_nxt;
  logic [CW-1:0]                       m_r, m_nxt;
  logic [CW-1:0]                       lim_r, lim_nxt;
  logic [CW-1:0]                       h_r, h_nxt;
  logic                                sym_r, sym_nxt;
  logic                                symm_r;
  logic [QW-1:0]                       qc_r;
  logic                                out_valid_r, out_valid_nxt;
  logic [sfir_pkg::SAMPLE_W-1:0]       out_data_r;
  logic                                out_clip_r;
  logic [sfir_pkg::MAX_COEFS-1:0]      cvld_r;

  logic                                in_acc;
  logic                                smp_acc;
  logic                                coef_acc;
  logic [sfir_pkg::SAMPLE_W-1:0]       in_sample;
  logic [sfir_pkg::CIDX_W-1:0]         in_cidx;
  logic [sfir_pkg::COEF_W-1:0]         in_cval;
  logic [QW-1:0]                       qp;
  logic [QW-1:0]                       qs;
  logic [CW-1:0]                       addr_c;
  logic [sfir_pkg::COEF_AW-1:0]        raddr;
  logic [sfir_pkg::COEF_AW-1:0]        waddr;
  logic                                out_load;
  logic [sfir_pkg::SAMPLE_W-1:0]       tap;
  logic [sfir_pkg::COEF_W-1:0]         coef_rd;
  logic [sfir_pkg::SAMPLE_W-1:0]       mac_filtered;
  logic                                mac_clipped;
  sfir_pkg::chain_ctl_t                chain_ctl;
  sfir_pkg::mac_ctl_t                  mac_ctl;

  assign in_sample = in_tdata[15:0];
  assign in_cidx   = in_tdata[22:16];
  assign in_cval   = in_tdata[38:23];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign smp_acc   = in_acc && (in_tuser[0] == sfir_pkg::MODE_SAMPLE);
  assign coef_acc  = in_acc && (in_tuser[0] == sfir_pkg::MODE_COEF) &&
                     (32'(in_cidx) < 32'(sfir_pkg::MAX_COEFS));
  assign waddr     = sfir_pkg::COEF_AW'(in_cidx);

  assign cfg_ready = 1'b1;

  assign qp = (qc_r > PQ_MAX) ? PQ_MAX : qc_r;
  assign qs = (qc_r > SQ_MAX) ? SQ_MAX : qc_r;

  // coefficient index: symmetric walk folds back at the centre tap, plain walk counts down
  always_comb begin
    if (sym_r) begin
      addr_c = (m_r <= h_r) ? (h_r - m_r) : (m_r - h_r);
    end else begin
      addr_c = lim_r - m_r - CW'(1);
    end
  end
  assign raddr = sfir_pkg::COEF_AW'(addr_c);

  assign out_load = (state_r == ST_FIN) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    m_nxt     = m_r;
    lim_nxt   = lim_r;
    h_nxt     = h_r;
    sym_nxt   = sym_r;
    case (state_r)
      ST_IDLE: begin
        if (smp_acc) begin
          state_nxt = ST_WALK;
          m_nxt     = '0;
          sym_nxt   = symm_r;
          h_nxt     = CW'({qs, 2'b00});
          lim_nxt   = symm_r ? CW'({qs, 3'b000}) + CW'(1) : CW'({qp, 2'b00});
        end
      end
      ST_WALK: begin
        m_nxt = m_r + CW'(1);
        if (m_r == M_LAST) begin
          state_nxt = ST_DRN1;
        end
      end
      ST_DRN1: state_nxt = ST_DRN2;
      ST_DRN2: state_nxt = ST_FIN;
      ST_FIN: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      m_r         <= '0;
      lim_r       <= '0;
      h_r         <= '0;
      sym_r       <= 1'b0;
      symm_r      <= 1'b0;
      qc_r        <= QW'(1);
      out_valid_r <= 1'b0;
      cvld_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      m_r         <= m_nxt;
      lim_r       <= lim_nxt;
      h_r         <= h_nxt;
      sym_r       <= sym_nxt;
      out_valid_r <= out_valid_nxt;
      if (coef_acc) begin
        cvld_r[waddr] <= 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sfir_pkg::REG_SYMMETRIC:  symm_r <= cfg_data[0];
          sfir_pkg::REG_QUAD_COUNT: qc_r   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= mac_filtered;
      out_clip_r <= mac_clipped;
    end
  end

  assign chain_ctl.load  = smp_acc;
  assign chain_ctl.shift = (state_r == ST_WALK) && (m_r != M_LAST);

  assign mac_ctl.clear = smp_acc;
  assign mac_ctl.act   = (state_r == ST_WALK) && (m_r < lim_r);
  assign mac_ctl.cvld  = cvld_r[raddr];

  sfir_ram #(
    .WIDTH (sfir_pkg::COEF_W),
    .DEPTH (sfir_pkg::MAX_COEFS)
  ) u_coef_ram (
    .clk     (clk),
    .wr_en   (coef_acc),
    .wr_addr (waddr),
    .wr_data (in_cval),
    .rd_addr (raddr),
    .rd_data (coef_rd)
  );

  sfir_chain u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (chain_ctl),
    .ld_data (in_sample),
    .tap     (tap)
  );

  sfir_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (mac_ctl),
    .tap      (tap),
    .coef     (coef_rd),
    .filtered (mac_filtered),
    .clipped  (mac_clipped)
  );

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_clip_r;

  a_smp_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
    smp_acc |=> (state_r == ST_WALK) && (m_r == '0))
    else $error("sample request did not start a ring walk");

  a_coef_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    coef_acc |=> cvld_r[$past(waddr)])
    else $error("coefficient write left its entry marked empty");

  a_walk_ends_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) && (m_r == M_LAST) |=> (state_r == ST_DRN1) && !$past(chain_ctl.shift))
    else $error("ring walk did not stop after one full turn");

  a_clip_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_clip_r |-> (out_data_r == sfir_pkg::SAT_MAX) ||
                                  (out_data_r == sfir_pkg::SAT_MIN))
    else $error("clipped result is not a saturation value");

endmodule

@@ rtl/core/sfir_ram.sv @@
`timescale 1ns / 1ps
// Generic simple dual-port RAM with registered read.
module sfir_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/sfir_cell.sv @@
`timescale 1ns / 1ps
// One delay-ring cell: holds a sample, loads a new one or takes its neighbor's.
module sfir_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          shift,
  input  logic                          load,
  input  logic [sfir_pkg::SAMPLE_W-1:0] ld_data,
  input  logic [sfir_pkg::SAMPLE_W-1:0] nb_in,
  output logic [sfir_pkg::SAMPLE_W-1:0] q
);

  logic [sfir_pkg::SAMPLE_W-1:0] q_r;
  logic [sfir_pkg::SAMPLE_W-1:0] q_nxt;

  always_comb begin
    q_nxt = q_r;
    if (load) begin
      q_nxt = ld_data;
    end else if (shift) begin
      q_nxt = nb_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

@@ rtl/core/sfir_chain.sv @@
`timescale 1ns / 1ps
// Ring of sample cells; the last cell is the load point and the tap.
module sfir_chain (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sfir_pkg::chain_ctl_t          ctl,
  input  logic [sfir_pkg::SAMPLE_W-1:0] ld_data,
  output logic [sfir_pkg::SAMPLE_W-1:0] tap
);

  localparam int N = sfir_pkg::RING_LEN;

  logic [sfir_pkg::SAMPLE_W-1:0] cell_q [N];

  for (genvar i = 0; i < N; i++) begin : g_cell
    sfir_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .shift   (ctl.shift),
      .load    ((i == N - 1) ? ctl.load : 1'b0),
      .ld_data (ld_data),
      .nb_in   (cell_q[(i + 1) % N]),
      .q       (cell_q[i])
    );
  end

  assign tap = cell_q[N-1];

endmodule

@@ rtl/core/sfir_mac.sv @@
`timescale 1ns / 1ps
// Pipelined multiply-accumulate with rounding shift and 16-bit saturation.
module sfir_mac (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sfir_pkg::mac_ctl_t            ctl,
  input  logic [sfir_pkg::SAMPLE_W-1:0] tap,
  input  logic [sfir_pkg::COEF_W-1:0]   coef,
  output logic [sfir_pkg::SAMPLE_W-1:0] filtered,
  output logic                          clipped
);

  localparam int AW = sfir_pkg::ACC_W;
  localparam int HI = sfir_pkg::FRAC_BITS + sfir_pkg::SAMPLE_W - 1;

  logic                                 act1_r;
  logic                                 cv1_r;
  logic signed [sfir_pkg::SAMPLE_W-1:0] tap1_r;
  logic signed [sfir_pkg::COEF_W-1:0]   coef_eff;
  logic signed [31:0]                   prod_nxt;
  logic signed [31:0]                   prod_r;
  logic                                 act2_r;
  logic signed [AW-1:0]                 acc_r;
  logic signed [AW-1:0]                 acc_nxt;
  logic [AW-1-HI:0]                     acc_hi;
  logic                                 fits;

  assign coef_eff = cv1_r ? $signed(coef) : '0;
  assign prod_nxt = coef_eff * tap1_r;

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.clear) begin
      acc_nxt = AW'(sfir_pkg::ROUND_BIAS);
    end else if (act2_r) begin
      acc_nxt = acc_r + AW'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act1_r <= 1'b0;
      cv1_r  <= 1'b0;
      act2_r <= 1'b0;
    end else begin
      act1_r <= ctl.act;
      cv1_r  <= ctl.cvld;
      act2_r <= act1_r;
    end
  end

  always_ff @(posedge clk) begin
    tap1_r <= $signed(tap);
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  // result fits when the output sign bit and all bits above it agree
  assign acc_hi   = acc_r[AW-1:HI];
  assign fits     = (&acc_hi) | ~(|acc_hi);
  assign clipped  = ~fits;
  assign filtered = fits ? acc_r[HI:sfir_pkg::FRAC_BITS] :
                    (acc_r[AW-1] ? sfir_pkg::SAT_MIN : sfir_pkg::SAT_MAX);

endmodule
